/* design/frame_interval_stutter_monitor_macros.svh */
// Assertion helpers for the stutter monitor; clock aclk and reset aresetn in scope.
`ifndef FRAME_INTERVAL_STUTTER_MONITOR_MACROS_SVH
`define FRAME_INTERVAL_STUTTER_MONITOR_MACROS_SVH

// Same-cycle implication.
`define FISM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FISM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fism_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fism_pkg;

    localparam int WINDOW_DEF        = 120;
    localparam int INTERVAL_BITS_DEF = 24;
    localparam int STAMP_W           = 64;
    localparam int CMD_W             = 2;
    localparam int VAR_W             = 48;
    localparam int BOUND_W           = 24;
    localparam int FRAMES_W          = 7;
    localparam int TOTAL_W           = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 48;

    localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_PRESENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ANALYZE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_PERCENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_LIMIT = 3'd4;

    localparam logic [BOUND_W-1:0]  MIN_INTERVAL_RST   = 24'd1000;
    localparam logic [BOUND_W-1:0]  MAX_INTERVAL_RST   = 24'd10000000;
    localparam logic [FRAMES_W-1:0] MIN_FRAMES_RST     = 7'd60;
    localparam logic [FRAMES_W-1:0] SPIKE_PERCENT_RST  = 7'd5;
    localparam logic [VAR_W-1:0]    VARIANCE_LIMIT_RST = 48'd6400000000;

    typedef struct packed {
        logic [BOUND_W-1:0]  min_interval;
        logic [BOUND_W-1:0]  max_interval;
        logic [FRAMES_W-1:0] min_frames;
        logic [FRAMES_W-1:0] spike_percent;
        logic [VAR_W-1:0]    variance_limit;
    } fism_cfg_t;

    typedef enum logic [1:0] {
        PASS_SUM,
        PASS_SQ,
        PASS_SPIKE,
        PASS_RANK
    } fism_pass_t;

    typedef enum logic {
        DIV_MEAN,
        DIV_VAR
    } fism_div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_GO,
        ST_SUM_RUN,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_SQ_GO,
        ST_SQ_RUN,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_SPIKE_GO,
        ST_SPIKE_RUN,
        ST_RANK_GO,
        ST_RANK_RUN,
        ST_RANK_STEP,
        ST_FINISH
    } fism_state_t;

    typedef struct packed {
        logic          present_en;
        logic          clear_en;
        logic          analyze_init;
        logic          pass_start;
        fism_pass_t    pass_kind;
        logic          div_start;
        fism_div_sel_t div_sel;
        logic          rank_step;
        logic          out_load;
    } fism_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic div_done;
        logic empty;
        logic last_bit;
        logic out_free;
    } fism_status_t;

endpackage
`default_nettype wire

/* design/fism_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module fism_div #(
    parameter int DVD_W = 56,
    parameter int DVS_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    rem_w;
    logic              ge;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        rem_w     = {rem_reg, quo_reg[DVD_W-1]};
        ge        = rem_w >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? DVS_W'(rem_w - {1'b0, dvs_reg}) : rem_w[DVS_W-1:0];
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* design/fism_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module fism_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fism_pkg::CMD_W-1:0]   s_command,
    input  fism_pkg::fism_status_t       status,
    output fism_pkg::fism_cmd_t          cmd
);
    import fism_pkg::*;

    fism_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_command == CMD_ANALYZE) begin
                    state_next = status.empty ? ST_FINISH : ST_SUM_GO;
                end
            end
            ST_SUM_GO:    state_next = ST_SUM_RUN;
            ST_SUM_RUN:   if (status.pass_done) state_next = ST_MEAN_GO;
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (status.div_done) state_next = ST_SQ_GO;
            ST_SQ_GO:     state_next = ST_SQ_RUN;
            ST_SQ_RUN:    if (status.pass_done) state_next = ST_VAR_GO;
            ST_VAR_GO:    state_next = ST_VAR_WAIT;
            ST_VAR_WAIT:  if (status.div_done) state_next = ST_SPIKE_GO;
            ST_SPIKE_GO:  state_next = ST_SPIKE_RUN;
            ST_SPIKE_RUN: if (status.pass_done) state_next = ST_RANK_GO;
            ST_RANK_GO:   state_next = ST_RANK_RUN;
            ST_RANK_RUN:  if (status.pass_done) state_next = ST_RANK_STEP;
            ST_RANK_STEP: state_next = status.last_bit ? ST_FINISH : ST_RANK_GO;
            ST_FINISH:    if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        cmd              = '0;
        cmd.pass_kind    = PASS_SUM;
        cmd.div_sel      = DIV_MEAN;
        case (state_reg)
            ST_IDLE: begin
                s_ready          = 1'b1;
                cmd.present_en   = s_valid && s_command == CMD_PRESENT;
                cmd.clear_en     = s_valid && s_command == CMD_CLEAR;
                cmd.analyze_init = s_valid && s_command == CMD_ANALYZE;
            end
            ST_SUM_GO: begin
                cmd.pass_start = 1'b1;
                cmd.pass_kind  = PASS_SUM;
            end
            ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
            end
            ST_SQ_GO: begin
                cmd.pass_start = 1'b1;
                cmd.pass_kind  = PASS_SQ;
            end
            ST_VAR_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VAR;
            end
            ST_SPIKE_GO: begin
                cmd.pass_start = 1'b1;
                cmd.pass_kind  = PASS_SPIKE;
            end
            ST_RANK_GO: begin
                cmd.pass_start = 1'b1;
                cmd.pass_kind  = PASS_RANK;
            end
            ST_RANK_STEP: cmd.rank_step = 1'b1;
            ST_FINISH:    cmd.out_load  = status.out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* design/fism_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module fism_dp #(
    parameter int WINDOW        = fism_pkg::WINDOW_DEF,
    parameter int INTERVAL_BITS = fism_pkg::INTERVAL_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fism_pkg::fism_cmd_t                 cmd,
    output fism_pkg::fism_status_t              status,
    input  fism_pkg::fism_cfg_t                 cfg,
    input  logic [fism_pkg::STAMP_W-1:0]        s_stamp,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_enough_data,
    output logic [INTERVAL_BITS-1:0]            m_mean_interval,
    output logic [fism_pkg::VAR_W-1:0]          m_interval_variance,
    output logic [INTERVAL_BITS-1:0]            m_tail_interval,
    output logic [$clog2(WINDOW+1)-1:0]         m_spike_count,
    output logic                                m_stutter,
    output logic [fism_pkg::TOTAL_W-1:0]        m_stutter_total,
    output logic [$clog2(WINDOW+1)-1:0]         m_window_count
);
    import fism_pkg::*;

    localparam int IB      = INTERVAL_BITS;
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW+1);
    localparam int SUM_W   = IB + CNT_W;
    localparam int SQ_W    = 2*IB + CNT_W;
    localparam int SPK_W   = (2*IB > VAR_W + 2) ? 2*IB : VAR_W + 2;
    localparam int VSAT_W  = (SQ_W > VAR_W) ? SQ_W : VAR_W;

    logic [IB-1:0] ring [WINDOW];

    // Window bookkeeping
    logic                 have_stamp_reg;
    logic [STAMP_W-1:0]   last_stamp_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [IDX_W-1:0]     wslot_reg;
    logic [STAMP_W-1:0]   gap;
    logic                 gap_ok;
    logic                 wr_en;

    // Sweep pipeline
    logic                 issue_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     last_idx;
    logic                 a_vld_reg, a_last_reg;
    logic [IB-1:0]        rd_data_reg;
    logic                 b_vld_reg, b_last_reg, b_gt_reg;
    logic [IB-1:0]        b_val_reg;
    logic [2*IB-1:0]      b_sq_reg;
    logic [IB-1:0]        abs_dev;
    fism_pass_t           kind_reg;
    fism_div_sel_t        div_sel_reg;

    // Statistics
    logic [SUM_W-1:0]     sum_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [IB-1:0]        mean_reg;
    logic [VAR_W-1:0]     var_reg;
    logic [CNT_W-1:0]     spikes_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     rank_reg;
    logic [IB-1:0]        prefix_reg, mask_reg, bsel_reg;
    logic                 spike_hit, rank_hit;
    logic [CNT_W-1:0]     rank_dec;

    // Divider
    logic [SQ_W-1:0]      div_dividend;
    logic                 div_done;
    logic [SQ_W-1:0]      div_quo;
    logic [VSAT_W-1:0]    quo_ext;

    // Output side
    logic                 m_valid_reg;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [15:0]          need;
    logic                 enough, share_over, var_over, stut;

    assign gap    = s_stamp - last_stamp_reg;
    assign gap_ok = gap > STAMP_W'(cfg.min_interval) && gap < STAMP_W'(cfg.max_interval)
                    && (gap >> IB) == '0;
    assign wr_en  = cmd.present_en && have_stamp_reg && gap_ok;

    assign last_idx = IDX_W'(fill_reg - CNT_W'(1));
    assign abs_dev  = (rd_data_reg >= mean_reg) ? rd_data_reg - mean_reg
                                                : mean_reg - rd_data_reg;

    assign spike_hit = b_gt_reg && (SPK_W'(b_sq_reg) > (SPK_W'(var_reg) << 2));
    assign rank_hit  = ((b_val_reg ^ prefix_reg) & mask_reg) == '0
                       && (b_val_reg & bsel_reg) == '0;

    // floor(n*99/100) equals n - ceil(n/100) over the window's range.
    assign rank_dec = (16'(fill_reg) > 16'd200) ? CNT_W'(3) :
                      (16'(fill_reg) > 16'd100) ? CNT_W'(2) : CNT_W'(1);

    assign div_dividend = (cmd.div_sel == DIV_MEAN) ? SQ_W'(sum_reg) : sq_reg;
    assign quo_ext      = VSAT_W'(div_quo);

    fism_div #(
        .DVD_W (SQ_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wslot_reg] <= gap[IB-1:0];
        end
        if (issue_reg) begin
            rd_data_reg <= ring[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_stamp_reg <= 1'b0;
            last_stamp_reg <= '0;
            fill_reg       <= '0;
            wslot_reg      <= '0;
            issue_reg      <= 1'b0;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            kind_reg       <= PASS_SUM;
            div_sel_reg    <= DIV_MEAN;
            m_valid_reg    <= 1'b0;
            total_reg      <= '0;
        end else begin
            if (cmd.present_en) begin
                if (!have_stamp_reg) begin
                    have_stamp_reg <= 1'b1;
                    last_stamp_reg <= s_stamp;
                end else if (gap_ok) begin
                    last_stamp_reg <= s_stamp;
                    wslot_reg <= (wslot_reg == IDX_W'(WINDOW - 1)) ? '0 : wslot_reg + 1'b1;
                    if (fill_reg != CNT_W'(WINDOW)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end
            if (cmd.clear_en) begin
                fill_reg  <= '0;
                wslot_reg <= '0;
            end
            if (cmd.pass_start) begin
                issue_reg <= 1'b1;
                kind_reg  <= cmd.pass_kind;
            end else if (issue_reg && idx_reg == last_idx) begin
                issue_reg <= 1'b0;
            end
            a_vld_reg <= issue_reg;
            b_vld_reg <= a_vld_reg;
            if (cmd.div_start) begin
                div_sel_reg <= cmd.div_sel;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                total_reg   <= total_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pass_start) begin
            idx_reg <= '0;
        end else if (issue_reg) begin
            idx_reg <= idx_reg + 1'b1;
        end
        a_last_reg <= issue_reg && idx_reg == last_idx;
        b_last_reg <= a_vld_reg && a_last_reg;
        b_val_reg  <= rd_data_reg;
        b_gt_reg   <= rd_data_reg > mean_reg;
        b_sq_reg   <= (2*IB)'(abs_dev) * (2*IB)'(abs_dev);

        if (cmd.analyze_init) begin
            sum_reg    <= '0;
            sq_reg     <= '0;
            mean_reg   <= '0;
            var_reg    <= '0;
            spikes_reg <= '0;
            prefix_reg <= '0;
            mask_reg   <= '0;
            bsel_reg   <= {1'b1, {(IB-1){1'b0}}};
            rank_reg   <= fill_reg - rank_dec;
        end
        if (cmd.pass_start) begin
            cnt_reg <= '0;
        end
        if (b_vld_reg) begin
            case (kind_reg)
                PASS_SUM:   sum_reg <= sum_reg + SUM_W'(b_val_reg);
                PASS_SQ:    sq_reg  <= sq_reg + SQ_W'(b_sq_reg);
                PASS_SPIKE: if (spike_hit) spikes_reg <= spikes_reg + 1'b1;
                PASS_RANK:  if (rank_hit) cnt_reg <= cnt_reg + 1'b1;
                default:    cnt_reg <= cnt_reg;
            endcase
        end
        if (div_done) begin
            if (div_sel_reg == DIV_MEAN) begin
                mean_reg <= IB'(div_quo);
            end else begin
                var_reg <= (quo_ext > VSAT_W'(VAR_MAX)) ? VAR_MAX : VAR_W'(div_quo);
            end
        end
        // Settle one bit of the ranked value: too few below means the bit is one.
        if (cmd.rank_step) begin
            if (rank_reg >= cnt_reg) begin
                prefix_reg <= prefix_reg | bsel_reg;
                rank_reg   <= rank_reg - cnt_reg;
            end
            mask_reg <= mask_reg | bsel_reg;
            bsel_reg <= bsel_reg >> 1;
        end
    end

    always_comb begin
        need       = (cfg.min_frames == '0) ? 16'd1 : 16'(cfg.min_frames);
        enough     = fill_reg != '0 && 16'(fill_reg) >= need;
        share_over = 17'(spikes_reg) * 17'd100 > 17'(cfg.spike_percent) * 17'(fill_reg);
        var_over   = var_reg > cfg.variance_limit;
        stut       = enough && (share_over || var_over);
        total_next = (stut && total_reg != TOTAL_MAX) ? total_reg + 1'b1 : total_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_enough_data       <= enough;
            m_mean_interval     <= mean_reg;
            m_interval_variance <= var_reg;
            m_tail_interval     <= prefix_reg;
            m_spike_count       <= spikes_reg;
            m_stutter           <= stut;
            m_stutter_total     <= total_next;
            m_window_count      <= fill_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign status.pass_done = b_vld_reg && b_last_reg;
    assign status.div_done  = div_done;
    assign status.empty     = fill_reg == '0;
    assign status.last_bit  = bsel_reg[0];
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

/* design/frame_interval_stutter_monitor.sv */
// Frame interval stutter monitor. On a present command (0) the gap since the
// last kept stamp enters a WINDOW-deep interval memory when it lies strictly
// between min_interval and max_interval. A clear command (2) empties the
// window; command 3 is dropped. An analyze command (1) returns one result;
// its run time is set by the single read port of the interval memory, walked
// once each for sum, squares and spikes and once per bit for the percentile
// rank select, and by the one-bit-per-cycle divider shared by mean and
// variance. An empty window skips the passes and goes straight to the
// result. A finished result waits in an output register.
`timescale 1ns / 1ps
`default_nettype none
module frame_interval_stutter_monitor #(
    parameter int WINDOW        = fism_pkg::WINDOW_DEF,
    parameter int INTERVAL_BITS = fism_pkg::INTERVAL_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fism_pkg::CMD_W-1:0]          s_command,
    input  logic [fism_pkg::STAMP_W-1:0]        s_stamp,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_enough_data,
    output logic [INTERVAL_BITS-1:0]            m_mean_interval,
    output logic [fism_pkg::VAR_W-1:0]          m_interval_variance,
    output logic [INTERVAL_BITS-1:0]            m_tail_interval,
    output logic [$clog2(WINDOW+1)-1:0]         m_spike_count,
    output logic                                m_stutter,
    output logic [fism_pkg::TOTAL_W-1:0]        m_stutter_total,
    output logic [$clog2(WINDOW+1)-1:0]         m_window_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fism_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fism_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fism_pkg::*;

`include "frame_interval_stutter_monitor_macros.svh"

    fism_cfg_t    cfg_reg;
    fism_cmd_t    cmd;
    fism_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_interval   <= MIN_INTERVAL_RST;
            cfg_reg.max_interval   <= MAX_INTERVAL_RST;
            cfg_reg.min_frames     <= MIN_FRAMES_RST;
            cfg_reg.spike_percent  <= SPIKE_PERCENT_RST;
            cfg_reg.variance_limit <= VARIANCE_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_INTERVAL:   cfg_reg.min_interval   <= cfg_data[BOUND_W-1:0];
                CFG_MAX_INTERVAL:   cfg_reg.max_interval   <= cfg_data[BOUND_W-1:0];
                CFG_MIN_FRAMES:     cfg_reg.min_frames     <= cfg_data[FRAMES_W-1:0];
                CFG_SPIKE_PERCENT:  cfg_reg.spike_percent  <= cfg_data[FRAMES_W-1:0];
                CFG_VARIANCE_LIMIT: cfg_reg.variance_limit <= cfg_data[VAR_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    fism_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (status),
        .cmd       (cmd)
    );

    fism_dp #(
        .WINDOW        (WINDOW),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg                 (cfg_reg),
        .s_stamp             (s_stamp),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_enough_data       (m_enough_data),
        .m_mean_interval     (m_mean_interval),
        .m_interval_variance (m_interval_variance),
        .m_tail_interval     (m_tail_interval),
        .m_spike_count       (m_spike_count),
        .m_stutter           (m_stutter),
        .m_stutter_total     (m_stutter_total),
        .m_window_count      (m_window_count)
    );

    `FISM_ASSERT_NOW(a_stutter_needs_data, m_valid && m_stutter, m_enough_data, "stutter without enough data")
    `FISM_ASSERT_NEXT(a_no_result_without_analyze, s_valid && s_ready && s_command != CMD_ANALYZE && !m_valid, !m_valid, "result from non-analyze transaction")
    `FISM_ASSERT_NEXT(a_analyze_blocks_input, s_valid && s_ready && s_command == CMD_ANALYZE, !s_ready, "input taken during analysis")

endmodule
`default_nettype wire
